// ===== design/tkm_pkg.sv =====
// Shared codes, widths and parameter defaults for the timestamp k-way merge unit.
package tkm_pkg;

    localparam int SOURCES_DEF     = 7;
    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int STAMP_BITS_DEF  = 48;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_PUSH  = 2'd0;
    localparam t_op OP_POP   = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_EMPTY   = 2'd1;
    localparam t_status ST_DROPPED = 2'd2;

endpackage

// ===== design/timestamp_kway_merge_unit.sv =====
// Top level of the timestamp k-way merge unit: queue control, head cache and result register.
//
// Merges per-source timestamp queues into one time-ordered stream. Each input word carries
// an op in tuser (push, pop earliest, clear) and a source index and timestamp in tdata; each
// input word yields exactly one output word with a status in tuser and the popped timestamp
// and its source in tdata (zero unless a pop found data). The queues live in one memory of
// SOURCES*QUEUE_DEPTH stamps; the oldest entry of each queue is cached in a head register so
// that a pop compares all heads at once. Ties go to the lower source index. A push to a full
// queue or to a source index at or above SOURCES is dropped with status 2; a pop with no
// enabled non-empty queue returns status 1. source_enable only gates pops; it is written
// through i_cfg_wr_en/i_cfg_wr_data; the user must write it only while the unit is idle,
// as the unit itself does not enforce this. Steps: one word at a time; s_axis_tready is
// high only while the unit is idle. A push, clear or unused op executes in the execute
// step after the accept and loads its result into the output register there. A pop
// compares the cached heads in the execute step and loads its result in the pop step;
// when the winning queue still holds entries, a fill step then refills its head from the
// queue memory, whose read data is registered. A finished result waits in the output
// register while the next word is accepted; if it is still waiting, the next word holds
// in its execute or pop step.
module timestamp_kway_merge_unit #(
    parameter int SOURCES     = tkm_pkg::SOURCES_DEF,
    parameter int QUEUE_DEPTH = tkm_pkg::QUEUE_DEPTH_DEF,
    parameter int STAMP_BITS  = tkm_pkg::STAMP_BITS_DEF,
    localparam int SRC_W      = ($clog2(SOURCES) > 3) ? $clog2(SOURCES) : 3,
    localparam int IN_W       = ((SRC_W + STAMP_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((STAMP_BITS + SRC_W + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: source_enable
    input  logic                         i_cfg_wr_en,
    input  logic [tkm_pkg::CFG_W-1:0]    i_cfg_wr_data,
    // input words
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [IN_W-1:0]              s_axis_tdata,  // source, stamp, zero pad
    input  logic [tkm_pkg::OP_W-1:0]     s_axis_tuser,  // op
    // result words
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [OUT_W-1:0]             m_axis_tdata,  // earliest, from_source, zero pad
    output logic [tkm_pkg::STATUS_W-1:0] m_axis_tuser   // status
);

    localparam int SIDX_W = $clog2(SOURCES);
    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH  = SOURCES * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_FILL
    } t_state;

    t_state                   r_state;
    tkm_pkg::t_op             r_op;
    logic [SRC_W-1:0]         r_src;
    logic [STAMP_BITS-1:0]    r_stamp;
    logic [tkm_pkg::CFG_W-1:0] r_cfg;

    // per-source queue pointers and cached heads
    logic [IDX_W-1:0]         r_rd   [SOURCES];
    logic [CNT_W-1:0]         r_cnt  [SOURCES];
    logic [STAMP_BITS-1:0]    r_head [SOURCES];

    // registered winner of the head compare
    logic                     r_win_found;
    logic [SIDX_W-1:0]        r_win_src;
    logic [STAMP_BITS-1:0]    r_win_stamp;

    // result register
    logic                     r_out_valid;
    tkm_pkg::t_status         r_out_status;
    logic [STAMP_BITS-1:0]    r_out_earliest;
    logic [SRC_W-1:0]         r_out_from;

    logic [SOURCES-1:0]       w_enable;
    logic [SOURCES-1:0]       w_live;
    logic                     w_found;
    logic [SIDX_W-1:0]        w_win_src;
    logic [STAMP_BITS-1:0]    w_win_stamp;

    logic                     w_out_free;
    logic                     w_out_load;
    logic [SIDX_W-1:0]        w_src_idx;
    logic                     w_drop;
    logic [IDX_W:0]           w_wr_sum;
    logic [IDX_W-1:0]         w_wr_idx;
    logic [IDX_W-1:0]         w_rd_next;
    logic [CNT_W-1:0]         w_win_cnt;

    logic                     w_wr_en;
    logic [ADDR_W-1:0]        w_wr_addr;
    logic                     w_rd_en;
    logic [ADDR_W-1:0]        w_rd_addr;
    logic [STAMP_BITS-1:0]    w_rd_data;

    // enable bits above the register width read as zero
    for (genvar s = 0; s < SOURCES; s++) begin : g_en
        if (s < tkm_pkg::CFG_W) begin : g_bit
            assign w_enable[s] = r_cfg[s];
        end else begin : g_zero
            assign w_enable[s] = 1'b0;
        end
        assign w_live[s] = w_enable[s] && (r_cnt[s] != '0);
    end

    tkm_min_tree #(
        .SOURCES    (SOURCES),
        .STAMP_BITS (STAMP_BITS),
        .SIDX_W     (SIDX_W)
    ) u_min_tree (
        .i_valid (w_live),
        .i_stamp (r_head),
        .o_found (w_found),
        .o_src   (w_win_src),
        .o_stamp (w_win_stamp)
    );

    always_comb begin
        w_out_free = !r_out_valid || m_axis_tready;
        // a result is loaded by the execute step of a non-pop or by the pop step
        w_out_load = w_out_free && (((r_state == S_EXEC) && (r_op != tkm_pkg::OP_POP))
                                    || (r_state == S_POP));
        w_src_idx  = r_src[SIDX_W-1:0];
        w_drop     = ({1'b0, r_src} >= (SRC_W+1)'(SOURCES))
                  || (r_cnt[w_src_idx] == CNT_W'(QUEUE_DEPTH));
        // tail slot = read index + count, wrapped once
        w_wr_sum   = (IDX_W+1)'(r_rd[w_src_idx]) + (IDX_W+1)'(r_cnt[w_src_idx]);
        if (w_wr_sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
            w_wr_idx = IDX_W'(w_wr_sum - (IDX_W+1)'(QUEUE_DEPTH));
        end else begin
            w_wr_idx = IDX_W'(w_wr_sum);
        end
        if (r_rd[r_win_src] == IDX_W'(QUEUE_DEPTH - 1)) begin
            w_rd_next = '0;
        end else begin
            w_rd_next = r_rd[r_win_src] + IDX_W'(1);
        end
        w_win_cnt  = r_cnt[r_win_src];

        w_wr_en    = (r_state == S_EXEC) && (r_op == tkm_pkg::OP_PUSH) && w_out_free && !w_drop;
        w_wr_addr  = ADDR_W'(w_src_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(w_wr_idx);
        // refill the head only when the winning queue keeps entries after this pop
        w_rd_en    = (r_state == S_POP) && w_out_free && r_win_found
                  && (w_win_cnt > CNT_W'(1));
        w_rd_addr  = ADDR_W'(r_win_src) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(w_rd_next);
    end

    tkm_stamp_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (STAMP_BITS)
    ) u_stamp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_stamp),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= '0;
            r_out_valid <= 1'b0;
            r_win_found <= 1'b0;
            for (int s = 0; s < SOURCES; s++) begin
                r_rd[s]  <= '0;
                r_cnt[s] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= s_axis_tuser;
                        r_src   <= s_axis_tdata[SRC_W-1:0];
                        r_stamp <= s_axis_tdata[SRC_W +: STAMP_BITS];
                        r_state <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    if (r_op == tkm_pkg::OP_POP) begin
                        r_win_found <= w_found;
                        r_win_src   <= w_win_src;
                        r_win_stamp <= w_win_stamp;
                        r_state     <= S_POP;
                    end else if (w_out_free) begin
                        r_out_status   <= ((r_op == tkm_pkg::OP_PUSH) && w_drop)
                                        ? tkm_pkg::ST_DROPPED : tkm_pkg::ST_OK;
                        r_out_earliest <= '0;
                        r_out_from     <= '0;
                        r_state        <= S_IDLE;
                        if (r_op == tkm_pkg::OP_PUSH) begin
                            if (!w_drop) begin
                                r_cnt[w_src_idx] <= r_cnt[w_src_idx] + CNT_W'(1);
                                // empty queue: the new stamp is the head, no memory read
                                if (r_cnt[w_src_idx] == '0) begin
                                    r_head[w_src_idx] <= r_stamp;
                                end
                            end
                        end else if (r_op == tkm_pkg::OP_CLEAR) begin
                            for (int s = 0; s < SOURCES; s++) begin
                                r_rd[s]  <= '0;
                                r_cnt[s] <= '0;
                            end
                        end
                    end
                end

                S_POP: begin
                    if (w_out_free) begin
                        if (r_win_found) begin
                            r_out_status       <= tkm_pkg::ST_OK;
                            r_out_earliest     <= r_win_stamp;
                            r_out_from         <= SRC_W'(r_win_src);
                            r_rd[r_win_src]    <= w_rd_next;
                            r_cnt[r_win_src]   <= w_win_cnt - CNT_W'(1);
                            r_state            <= w_rd_en ? S_FILL : S_IDLE;
                        end else begin
                            r_out_status   <= tkm_pkg::ST_EMPTY;
                            r_out_earliest <= '0;
                            r_out_from     <= '0;
                            r_state        <= S_IDLE;
                        end
                    end
                end

                S_FILL: begin
                    r_head[r_win_src] <= w_rd_data;
                    r_state           <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = OUT_W'({r_out_from, r_out_earliest});

    // a winner must come from an enabled queue that holds data
    a_win_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP && r_win_found) |-> (w_enable[r_win_src] && r_cnt[r_win_src] != '0))
        else $error("pop winner not enabled or empty");

    // a head refill read is always followed by the head load
    a_fill_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |=> (r_state == S_FILL))
        else $error("head refill read not followed by load");

    // the refill only happens for a queue that is still non-empty
    a_fill_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_cnt[r_win_src] != '0))
        else $error("head refill for an empty queue");

    // a result with a non-ok status (empty pop or dropped push) carries zero payload
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != tkm_pkg::ST_OK) |-> (r_out_earliest == '0
            && r_out_from == '0))
        else $error("non-ok result with nonzero payload");

endmodule

// ===== design/tkm_stamp_ram.sv =====
// Timestamp queue memory: one write port, one read port, registered read data.
module tkm_stamp_ram #(
    parameter int DEPTH  = tkm_pkg::SOURCES_DEF * tkm_pkg::QUEUE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = tkm_pkg::STAMP_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/tkm_min_tree.sv =====
// Tournament tree picking the earliest valid head; ties go to the lower source.
module tkm_min_tree #(
    parameter int SOURCES    = tkm_pkg::SOURCES_DEF,
    parameter int STAMP_BITS = tkm_pkg::STAMP_BITS_DEF,
    parameter int SIDX_W     = $clog2(SOURCES)
) (
    input  logic [SOURCES-1:0]    i_valid,
    input  logic [STAMP_BITS-1:0] i_stamp [SOURCES],
    output logic                  o_found,
    output logic [SIDX_W-1:0]     o_src,
    output logic [STAMP_BITS-1:0] o_stamp
);

    localparam int LEAVES = 1 << SIDX_W;

    logic                  w_nv [2*LEAVES];
    logic [STAMP_BITS-1:0] w_nt [2*LEAVES];
    logic [SIDX_W-1:0]     w_ns [2*LEAVES];

    always_comb begin
        for (int i = 0; i < 2*LEAVES; i++) begin
            w_nv[i] = 1'b0;
            w_nt[i] = '0;
            w_ns[i] = '0;
        end
        for (int i = 0; i < SOURCES; i++) begin
            w_nv[LEAVES+i] = i_valid[i];
            w_nt[LEAVES+i] = i_stamp[i];
            w_ns[LEAVES+i] = SIDX_W'(i);
        end
        // left child holds the lower indices, so it wins on equal stamps
        for (int n = LEAVES-1; n >= 1; n--) begin
            if (w_nv[2*n] && (!w_nv[2*n+1] || (w_nt[2*n] <= w_nt[2*n+1]))) begin
                w_nv[n] = w_nv[2*n];
                w_nt[n] = w_nt[2*n];
                w_ns[n] = w_ns[2*n];
            end else begin
                w_nv[n] = w_nv[2*n+1];
                w_nt[n] = w_nt[2*n+1];
                w_ns[n] = w_ns[2*n+1];
            end
        end
    end

    assign o_found = w_nv[1];
    assign o_src   = w_ns[1];
    assign o_stamp = w_nt[1];

endmodule
